>>> rtl/lfdt_pkg.sv
// Package for the lowest-free descriptor table: table sizes, opcode and status
// codes, beat types of both channels and the table update record.
// No dependencies.
package lfdt_pkg;

	// Table geometry
	localparam int NUM_FDS     = 64;
	localparam int HANDLE_BITS = 16;
	localparam int SLOT_BITS   = $clog2(NUM_FDS);
	localparam int INIT_SLOTS  = 3;

	// Fixed field widths of the channels
	localparam int DESC_BITS   = 6;
	localparam int HOUT_BITS   = 16;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_GET   = 3'd1,
		OP_CLOSE = 3'd2,
		OP_DUP   = 3'd3,
		OP_DUP2  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BADF = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]           opcode;
		logic [DESC_BITS-1:0] desc;
		logic [DESC_BITS-1:0] target_desc;
		logic [15:0]          handle_in;
	} req_t;

	typedef struct packed {
		logic [DESC_BITS-1:0] result_desc;
		logic [HOUT_BITS-1:0] handle_out;
		logic [1:0]           status;
	} rsp_t;

	// One table update: a slot, its valid bit and optionally its handle
	typedef struct packed {
		logic                   valid_we;
		logic                   valid_val;
		logic                   mem_we;
		logic [SLOT_BITS-1:0]   slot;
		logic [HANDLE_BITS-1:0] handle;
	} upd_t;

	function automatic logic [SLOT_BITS-1:0] to_slot(input logic [DESC_BITS-1:0] d);
		return SLOT_BITS'(d);
	endfunction

	function automatic logic in_range(input logic [DESC_BITS-1:0] d);
		return int'(d) < NUM_FDS;
	endfunction

endpackage

>>> rtl/lowest_free_descriptor_table_core.sv
// Lowest-free descriptor table, top level: request register, operation unit,
// response register, valid bitmap and handle RAM. Depends on lfdt_pkg,
// lfdt_handle_ram and lfdt_exec.
//
// Usage: the req channel (req_valid/req_ready/req) carries one operation per
// beat: allocate, get, close, dup or dup2. The rsp channel
// (rsp_valid/rsp_ready/rsp) returns exactly one response beat per request, in
// order, with the slot, the handle read by get and a status.
// The handle RAM read and the request are registered in stage 1, then the
// operation unit works out the result and table update combinationally, using
// the priority encoder over the valid bitmap, into the response register.
// Throughput is one request per cycle while the receiver takes responses; a
// write to the table is forwarded to a request read in the same cycle.
// Reset clears the valid bits of both pipeline registers and leaves slots 0,
// 1 and 2 in use with handles 0, 1 and 2; all other slots are free. No clearing
// pass is needed, so requests are taken from the first cycle after reset.
// When the receiver stalls, the response register holds its beat, the request
// register holds the next one, and req_ready falls until rsp_ready returns.
module lowest_free_descriptor_table_core
	import lfdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic                   accept;
	logic                   commit;
	logic                   valid_s1;
	req_t                   req_s1;
	logic                   byp_hit;
	logic                   byp_s1;
	logic [HANDLE_BITS-1:0] byp_handle_s1;
	logic                   init_hit_s1;
	logic [HANDLE_BITS-1:0] ram_rdata;
	logic [HANDLE_BITS-1:0] src_handle;
	logic [NUM_FDS-1:0]     slot_valid_q;
	logic [INIT_SLOTS-1:0]  init_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	rsp_t                   exec_rsp;
	upd_t                   upd;

	// Handshake: stage 1 moves on when the response register is empty or being read
	assign commit    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || commit;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Forward a handle written this cycle to a request reading the same slot
	assign byp_hit = commit && upd.mem_we && (upd.slot == to_slot(req.desc));

	lfdt_handle_ram #(
		.DEPTH(NUM_FDS),
		.WIDTH(HANDLE_BITS)
	) u_ram (
		.clk  (clk),
		.we   (commit && upd.mem_we),
		.waddr(upd.slot),
		.wdata(upd.handle),
		.re   (accept),
		.raddr(to_slot(req.desc)),
		.rdata(ram_rdata)
	);

	// Source handle: forwarded, stdio reset value, or RAM
	always_comb begin
		if (byp_s1) begin
			src_handle = byp_handle_s1;
		end else if (init_hit_s1) begin
			src_handle = HANDLE_BITS'(req_s1.desc);
		end else begin
			src_handle = ram_rdata;
		end
	end

	lfdt_exec u_exec (
		.req       (req_s1),
		.slot_valid(slot_valid_q),
		.src_handle(src_handle),
		.rsp       (exec_rsp),
		.upd       (upd)
	);

	// Stage 1 and response control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 payload: capture the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1        <= req;
			byp_s1        <= byp_hit;
			byp_handle_s1 <= upd.handle;
			init_hit_s1   <= (int'(req.desc) < INIT_SLOTS) && init_q[req.desc[1:0]];
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= exec_rsp;
		end
	end

	// Valid bitmap and stdio reset marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= NUM_FDS'({INIT_SLOTS{1'b1}});
			init_q       <= '1;
		end else if (commit) begin
			if (upd.valid_we) begin
				slot_valid_q[upd.slot] <= upd.valid_val;
			end
			if (upd.mem_we && (int'(upd.slot) < INIT_SLOTS)) begin
				init_q[upd.slot[1:0]] <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// Allocate and dup only ever take a free slot
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit && upd.valid_we && upd.valid_val &&
		(req_s1.opcode == OP_ALLOC || req_s1.opcode == OP_DUP)
		|-> !slot_valid_q[upd.slot])
		else $error("allocation picked a slot in use");

	// A close leaves its slot free
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && upd.valid_we && !upd.valid_val
		|=> !slot_valid_q[$past(upd.slot)])
		else $error("closed slot still marked in use");

	// A stalled response blocks the request side when stage 1 is full
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("request accepted while pipeline is blocked");

	// Error responses carry zero slot and handle
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK
		|-> rsp_q.result_desc == '0 && rsp_q.handle_out == '0)
		else $error("error response with non-zero payload");
`endif

endmodule

>>> rtl/lfdt_handle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the stored handles of the descriptor table. No dependencies.
module lfdt_handle_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/lfdt_exec.sv
// Operation unit: decodes one request against the valid bitmap and the source
// handle, finds the lowest free slot and forms the response and table update.
// Depends on lfdt_pkg.
module lfdt_exec
	import lfdt_pkg::*;
(
	input  req_t                   req,
	input  logic [NUM_FDS-1:0]     slot_valid,
	input  logic [HANDLE_BITS-1:0] src_handle,
	output rsp_t                   rsp,
	output upd_t                   upd
);

	logic                 full;
	logic [SLOT_BITS-1:0] free_slot;
	logic                 src_ok;
	logic                 tgt_ok;
	logic [1:0]           status;
	logic [DESC_BITS-1:0] rdesc;
	logic [HOUT_BITS-1:0] hout;

	// Priority encoder: lowest clear bit of the bitmap
	always_comb begin
		free_slot = '0;
		for (int i = NUM_FDS - 1; i >= 0; i--) begin
			if (!slot_valid[i]) begin
				free_slot = SLOT_BITS'(i);
			end
		end
	end

	assign full   = &slot_valid;
	assign src_ok = in_range(req.desc) && slot_valid[to_slot(req.desc)];
	assign tgt_ok = in_range(req.target_desc);

	// Decode the operation
	always_comb begin
		status = ST_OK;
		rdesc  = '0;
		hout   = '0;
		upd    = '0;
		case (req.opcode)
			OP_ALLOC: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					rdesc         = DESC_BITS'(free_slot);
					upd.valid_we  = 1'b1;
					upd.valid_val = 1'b1;
					upd.mem_we    = 1'b1;
					upd.slot      = free_slot;
					upd.handle    = HANDLE_BITS'(req.handle_in);
				end
			end
			OP_GET: begin
				if (src_ok) begin
					rdesc = req.desc;
					hout  = HOUT_BITS'(src_handle);
				end else begin
					status = ST_BADF;
				end
			end
			OP_CLOSE: begin
				if (src_ok) begin
					rdesc         = req.desc;
					upd.valid_we  = 1'b1;
					upd.valid_val = 1'b0;
					upd.slot      = to_slot(req.desc);
				end else begin
					status = ST_BADF;
				end
			end
			OP_DUP: begin
				if (!src_ok) begin
					status = ST_BADF;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					rdesc         = DESC_BITS'(free_slot);
					upd.valid_we  = 1'b1;
					upd.valid_val = 1'b1;
					upd.mem_we    = 1'b1;
					upd.slot      = free_slot;
					upd.handle    = src_handle;
				end
			end
			OP_DUP2: begin
				if (!src_ok) begin
					status = ST_BADF;
				end else if (req.desc == req.target_desc) begin
					rdesc = req.target_desc;
				end else if (!tgt_ok) begin
					status = ST_BADF;
				end else begin
					rdesc         = req.target_desc;
					upd.valid_we  = 1'b1;
					upd.valid_val = 1'b1;
					upd.mem_we    = 1'b1;
					upd.slot      = to_slot(req.target_desc);
					upd.handle    = src_handle;
				end
			end
			default: begin
				status = ST_BADF;
			end
		endcase
	end

	// Errors report slot and handle as zero
	always_comb begin
		rsp.status      = status;
		rsp.result_desc = (status == ST_OK) ? rdesc : '0;
		rsp.handle_out  = (status == ST_OK) ? hout : '0;
	end

endmodule

>>> tb/lfdt_checker.sv
`timescale 1ns / 100ps
// Response checker for the lowest-free descriptor table: keeps its own copy of
// the slot bitmap and handles, predicts each response and compares it.
// Depends on lfdt_pkg.
module lfdt_checker
	import lfdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding,
	output int   ops_seen,
	output int   full_seen,
	output int   badf_seen
);

	// Shadow of the descriptor table
	logic [NUM_FDS-1:0]     fd_open;
	logic [HANDLE_BITS-1:0] fd_node [NUM_FDS];

	// Responses still owed by the block, oldest first
	rsp_t due_answers [$];

	int n_bad, n_ops, n_full, n_badf;

	// Lowest closed slot, or -1 when every slot is open
	function automatic int first_free_fd();
		for (int i = 0; i < NUM_FDS; i++) begin
			if (!fd_open[i])
				return i;
		end
		return -1;
	endfunction

	// Apply one operation to the shadow table and work out its response
	task automatic predict_answer(input req_t r, output rsp_t ans);
		int      src;
		int      dst;
		int      slot;
		logic    src_open;
		status_t st;
		ans      = '0;
		st       = ST_OK;
		slot     = 0;
		src      = int'(r.desc);
		dst      = int'(r.target_desc);
		src_open = (src < NUM_FDS) && fd_open[src];
		case (r.opcode)
			OP_ALLOC: begin
				slot = first_free_fd();
				if (slot < 0) begin
					st = ST_FULL;
				end else begin
					fd_open[slot] = 1'b1;
					fd_node[slot] = HANDLE_BITS'(r.handle_in);
				end
			end
			OP_GET: begin
				if (!src_open) begin
					st = ST_BADF;
				end else begin
					slot           = src;
					ans.handle_out = HOUT_BITS'(fd_node[src]);
				end
			end
			OP_CLOSE: begin
				if (!src_open) begin
					st = ST_BADF;
				end else begin
					fd_open[src] = 1'b0;
					fd_node[src] = '0;
					slot         = src;
				end
			end
			OP_DUP: begin
				if (!src_open) begin
					st = ST_BADF;
				end else begin
					// source is checked before the table is found full
					slot = first_free_fd();
					if (slot < 0) begin
						st = ST_FULL;
					end else begin
						fd_open[slot] = 1'b1;
						fd_node[slot] = fd_node[src];
					end
				end
			end
			OP_DUP2: begin
				if (!src_open) begin
					st = ST_BADF;
				end else if (src == dst) begin
					// onto itself: answer the slot, touch nothing
					slot = dst;
				end else if (dst >= NUM_FDS) begin
					st = ST_BADF;
				end else begin
					fd_node[dst] = fd_node[src];
					fd_open[dst] = 1'b1;
					slot         = dst;
				end
			end
			default: begin
				st = ST_BADF;
			end
		endcase
		// any failure answers slot 0 and no handle
		if (st != ST_OK) begin
			slot           = 0;
			ans.handle_out = '0;
		end
		ans.result_desc = DESC_BITS'(slot);
		ans.status      = st;
	endtask

	// Match responses against the queue, then record the new request
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			fd_open = '0;
			for (int i = 0; i < NUM_FDS; i++) begin
				fd_node[i] = '0;
			end
			for (int i = 0; i < INIT_SLOTS; i++) begin
				fd_open[i] = 1'b1;
				fd_node[i] = HANDLE_BITS'(i);
			end
			due_answers.delete();
			n_bad  = 0;
			n_ops  = 0;
			n_full = 0;
			n_badf = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_answers.size() == 0) begin
					$error("response beat with nothing outstanding: %p", rsp);
					n_bad++;
				end else begin
					want = due_answers.pop_front();
					if (rsp.result_desc != want.result_desc) begin
						$error("result_desc: expected %0d, got %0d",
							want.result_desc, rsp.result_desc);
						n_bad++;
					end
					if (rsp.handle_out != want.handle_out) begin
						$error("handle_out: expected 0x%04h, got 0x%04h",
							want.handle_out, rsp.handle_out);
						n_bad++;
					end
					if (rsp.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						n_bad++;
					end
				end
			end
			if (req_valid && req_ready) begin
				predict_answer(req, want);
				// append at the tail of the queue
				due_answers = {due_answers, want};
				n_ops++;
				if (want.status == ST_FULL)
					n_full++;
				else if (want.status == ST_BADF)
					n_badf++;
			end
		end
		// publish on the edge so readers always see settled values
		mismatches  <= n_bad;
		outstanding <= due_answers.size();
		ops_seen    <= n_ops;
		full_seen   <= n_full;
		badf_seen   <= n_badf;
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the descriptor table testbench: clock, reset, request and response
// drivers, watchdog and verdict. Depends on lfdt_pkg, lfdt_checker and the core.
module tb_top
	import lfdt_pkg::*;
();

	localparam int N_PHASES     = 18;
	localparam int PHASE_ITEMS  = 100;
	localparam int PAUSE_PHASE  = 9;
	localparam int LONG_HOLD    = 200;
	localparam int HOLD_AFTER   = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 6;

	localparam logic [2:0] OP_UNDEF_LO = 3'd5;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;

	// Operation mixes of the random phases
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_CHURN
	} mix_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int   mismatches, outstanding, ops_seen, full_seen, badf_seen;
	int   sent;
	bit   tx_idle;
	bit   rx_idle;
	int   quiet_cycles;

	lowest_free_descriptor_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	lfdt_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.ops_seen    (ops_seen),
		.full_seen   (full_seen),
		.badf_seen   (badf_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_t mk_op(input logic [2:0] op, input int src, input int dst,
			input logic [15:0] h);
		req_t r;
		r.opcode      = op;
		r.desc        = DESC_BITS'(src);
		r.target_desc = DESC_BITS'(dst);
		r.handle_in   = h;
		return r;
	endfunction

	// Random operation: slots drawn mostly from the low span, some anywhere
	function automatic req_t random_op(input mix_t mix, input int span);
		req_t r;
		int   pick;
		int   c_alloc, c_get, c_close, c_dup;
		case (mix)
			MIX_FILL: begin
				c_alloc = 50; c_get = 65; c_close = 70; c_dup = 90;
			end
			MIX_DRAIN: begin
				c_alloc = 15; c_get = 35; c_close = 85; c_dup = 90;
			end
			default: begin
				c_alloc = 20; c_get = 40; c_close = 60; c_dup = 80;
			end
		endcase
		r.handle_in   = 16'($urandom);
		r.desc        = ($urandom_range(0, 3) == 0) ? DESC_BITS'($urandom_range(0, 63))
		                                            : DESC_BITS'($urandom_range(0, span));
		r.target_desc = ($urandom_range(0, 7) == 0) ? r.desc
		                                            : DESC_BITS'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < 3)
			r.opcode = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		else begin
			pick = $urandom_range(0, 99);
			if (pick < c_alloc)
				r.opcode = OP_ALLOC;
			else if (pick < c_get)
				r.opcode = OP_GET;
			else if (pick < c_close)
				r.opcode = OP_CLOSE;
			else if (pick < c_dup)
				r.opcode = OP_DUP;
			else
				r.opcode = OP_DUP2;
		end
		return r;
	endfunction

	// Offer one beat, maybe after an idle burst, and hold it until taken
	task automatic offer(input req_t r);
		int gap;
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	// Request side: reset, directed beats, random phases, drain and verdict
	initial begin
		mix_t mix;
		int   span;
		sent      = 0;
		tx_idle   = 1'b1;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		rx_idle   <= 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// stdio slots, empty slots, extremes of handle and slot number
		offer(mk_op(OP_GET, 0, 0, 16'h0000));
		offer(mk_op(OP_GET, 2, 0, 16'h0000));
		offer(mk_op(OP_GET, 3, 0, 16'h0000));
		offer(mk_op(OP_CLOSE, 63, 0, 16'h0000));
		offer(mk_op(OP_ALLOC, 0, 0, 16'hFFFF));
		offer(mk_op(OP_ALLOC, 63, 63, 16'h0000));
		offer(mk_op(OP_DUP, 3, 0, 16'h0000));
		offer(mk_op(OP_DUP2, 3, 63, 16'h0000));
		offer(mk_op(OP_GET, 63, 0, 16'h0000));
		offer(mk_op(OP_DUP2, 63, 63, 16'h0000));
		offer(mk_op(OP_DUP2, 10, 5, 16'h0000));
		offer(mk_op(OP_DUP2, 1, 3, 16'h0000));
		offer(mk_op(OP_GET, 3, 0, 16'h0000));
		offer(mk_op(OP_CLOSE, 4, 0, 16'h0000));
		offer(mk_op(OP_ALLOC, 0, 0, 16'h1234));
		offer(mk_op(OP_UNDEF_LO, 1, 1, 16'h0000));
		offer(mk_op(OP_UNDEF_LO + 3'd1, 2, 0, 16'h5555));
		offer(mk_op(OP_UNDEF_HI, 63, 63, 16'hFFFF));
		offer(mk_op(OP_DUP, 40, 0, 16'h0000));
		offer(mk_op(OP_CLOSE, 0, 0, 16'h0000));
		offer(mk_op(OP_GET, 0, 0, 16'h0000));
		offer(mk_op(OP_ALLOC, 0, 0, 16'hAAAA));
		offer(mk_op(OP_DUP2, 2, 0, 16'h0000));
		offer(mk_op(OP_CLOSE, 63, 0, 16'h0000));
		offer(mk_op(OP_GET, 63, 0, 16'h0000));

		// random phases: fill to full, drain, churn; quiet towards the end
		for (int ph = 0; ph < N_PHASES; ph++) begin
			mix     = mix_t'(ph % 3);
			span    = (ph % 4 == 2) ? 15 : 63;
			tx_idle = (ph % 4 != 1) && (ph < N_PHASES - 2);
			rx_idle <= (ph % 4 != 3) && (ph < N_PHASES - 2);
			if (ph == PAUSE_PHASE) begin
				// hold off until the block has answered everything
				req_valid <= 1'b0;
				do @(posedge clk); while (ops_seen != sent || outstanding != 0);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				offer(random_op(mix, span));
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (ops_seen != sent || outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d table operations through fill, drain and churn mixes;", ops_seen);
		$display("%0d answered table full, %0d answered bad descriptor.", full_seen, badf_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS lowest_free_descriptor_table_core");
		else
			$display("FAIL lowest_free_descriptor_table_core");
		$finish;
	end

	// Response side: random stalls, plus one long hold-off to back the block up
	initial begin
		int hold;
		bit long_done;
		hold      = 0;
		long_done = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!long_done && ops_seen >= HOLD_AFTER) begin
				long_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (hold > 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 10) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL lowest_free_descriptor_table_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
